// ===== rtl/assert_macros.svh =====
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, quiet while reset is held
`define LAT_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("check failed");

// next-cycle implication, quiet while reset is held
`define LAT_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("check failed");

`endif

// ===== rtl/lat_pkg.sv =====
package lat_pkg;

    localparam int MAX_LEN   = 256;
    localparam int IDX_W     = $clog2(MAX_LEN);
    localparam int LEN_W     = $clog2(MAX_LEN + 1);
    localparam int SCORE_W   = 32;
    localparam int FRAC_W    = 16;
    localparam int DRAIN_CYC = 2 * MAX_LEN + 8;
    localparam int DRAIN_W   = $clog2(DRAIN_CYC);

    typedef logic signed [SCORE_W-1:0] t_score;

    localparam t_score SCORE_ZERO = '0;
    localparam t_score SCORE_MAX  = {1'b0, {(SCORE_W-1){1'b1}}};
    localparam t_score SCORE_MIN  = {1'b1, {(SCORE_W-1){1'b0}}};

    // trace labels
    typedef enum logic [1:0] {
        LAB_START,
        LAB_ALIGN,
        LAB_DOWN,
        LAB_RIGHT
    } t_label;

    // request kinds
    typedef enum logic [2:0] {
        KIND_CELL,
        KIND_ROW_GAP,
        KIND_COL_GAP,
        KIND_RUN,
        KIND_READ
    } t_kind;

    // configuration register indexes
    localparam logic [1:0] CFG_GAP_EXT = 2'd0;
    localparam logic [1:0] CFG_ROWS    = 2'd1;
    localparam logic [1:0] CFG_COLS    = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_GAP_SWEEP,
        ST_ROW_FEED,
        ST_DRAIN,
        ST_TB_WAIT,
        ST_TB_STEP
    } t_state;

    // data handed from one cell to the next
    typedef struct packed {
        logic             vld;
        logic [IDX_W-1:0] row;
        t_score           s;
        t_label           lab;
        t_score           gap;
        t_score           gap_scl;
    } t_link;

    // running best along the chain
    typedef struct packed {
        t_score           score;
        logic [LEN_W-1:0] row;
        logic [LEN_W-1:0] col;
    } t_best;

    // broadcast control from the sequencer to all cells
    typedef struct packed {
        logic             clear;
        logic             cg_we;
        logic [IDX_W-1:0] cg_idx;
        t_score           cg;
        t_score           cg_scl;
        logic             ld_we;
        logic [IDX_W-1:0] ld_row;
        logic [IDX_W-1:0] ld_col;
        t_score           ld_val;
        logic [LEN_W-1:0] cols;
        logic [IDX_W-1:0] tb_row;
    } t_ctl;

    function automatic t_score sat_add(input t_score a, input t_score b);
        logic signed [SCORE_W:0] sum;
        sum = {a[SCORE_W-1], a} + {b[SCORE_W-1], b};
        if (sum[SCORE_W] != sum[SCORE_W-1]) begin
            return sum[SCORE_W] ? SCORE_MIN : SCORE_MAX;
        end
        return sum[SCORE_W-1:0];
    endfunction

endpackage

// ===== rtl/lat_cell.sv =====
`include "assert_macros.svh"

module lat_cell (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic [lat_pkg::IDX_W-1:0] i_idx,
    input  lat_pkg::t_ctl           i_ctl,
    input  lat_pkg::t_link          i_link,
    output lat_pkg::t_link          o_link,
    input  lat_pkg::t_best          i_best,
    output lat_pkg::t_best          o_best,
    output lat_pkg::t_label         o_tb_lab
);
    import lat_pkg::*;

    t_score           r_cell_mem [MAX_LEN];
    t_label           r_lab_mem  [MAX_LEN];
    t_score           r_cell_rd;
    t_label           r_tb_rd;
    t_score           r_cg;
    t_score           r_cg_scl;
    t_score           r_diag;
    t_score           r_up_s;
    t_label           r_up_lab;
    t_score           r_best_s;
    logic [LEN_W-1:0] r_best_row;
    t_link            r_link;
    t_best            r_best_out;

    logic [IDX_W-1:0] w_rd_addr;
    logic             w_first;
    logic             w_in_use;
    logic             w_own_better;
    t_score           w_diag, w_up, w_a, w_d, w_r, w_s;
    t_label           w_up_lab, w_lab;
    t_best            w_own;

    // prefetch the score of the row that comes next
    assign w_rd_addr = i_link.vld ? i_link.row + IDX_W'(1) : '0;

    // column slice of the cell scores
    always_ff @(posedge i_clk) begin
        if (i_ctl.ld_we && i_ctl.ld_col == i_idx) begin
            r_cell_mem[i_ctl.ld_row] <= i_ctl.ld_val;
        end
        r_cell_rd <= r_cell_mem[w_rd_addr];
    end

    // column slice of the trace labels
    always_ff @(posedge i_clk) begin
        if (i_link.vld) begin
            r_lab_mem[i_link.row] <= w_lab;
        end
        r_tb_rd <= r_lab_mem[i_ctl.tb_row];
    end

    // recurrence for one grid cell
    always_comb begin
        w_first  = (i_link.row == '0);
        w_diag   = w_first ? SCORE_ZERO : r_diag;
        w_up     = w_first ? SCORE_ZERO : r_up_s;
        w_up_lab = w_first ? LAB_START : r_up_lab;
        w_a = sat_add(w_diag, r_cell_rd);
        w_d = sat_add(w_up, (w_up_lab == LAB_ALIGN) ? r_cg : r_cg_scl);
        w_r = sat_add(i_link.s, (i_link.lab == LAB_ALIGN) ? i_link.gap : i_link.gap_scl);
        if (w_a <= SCORE_ZERO && w_d <= SCORE_ZERO && w_r <= SCORE_ZERO) begin
            w_s   = SCORE_ZERO;
            w_lab = LAB_START;
        end else if (w_a >= w_r) begin
            if (w_a >= w_d) begin
                w_s   = w_a;
                w_lab = LAB_ALIGN;
            end else begin
                w_s   = w_d;
                w_lab = LAB_DOWN;
            end
        end else if (w_r >= w_d) begin
            w_s   = w_r;
            w_lab = LAB_RIGHT;
        end else begin
            w_s   = w_d;
            w_lab = LAB_DOWN;
        end
    end

    assign w_in_use = ({1'b0, i_idx} < i_ctl.cols);

    // column gap, full and scaled
    always_ff @(posedge i_clk) begin
        if (i_ctl.cg_we && i_ctl.cg_idx == i_idx) begin
            r_cg     <= i_ctl.cg;
            r_cg_scl <= i_ctl.cg_scl;
        end
    end

    // neighbor values kept from the previous row
    always_ff @(posedge i_clk) begin
        if (i_link.vld) begin
            r_diag   <= i_link.s;
            r_up_s   <= w_s;
            r_up_lab <= w_lab;
        end
    end

    // link toward the next cell
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_link.vld <= 1'b0;
        end else begin
            r_link.vld <= i_link.vld;
        end
        r_link.row     <= i_link.row;
        r_link.s       <= w_s;
        r_link.lab     <= w_lab;
        r_link.gap     <= i_link.gap;
        r_link.gap_scl <= i_link.gap_scl;
    end

    // first strict maximum of this column
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.clear) begin
            r_best_s   <= SCORE_ZERO;
            r_best_row <= '0;
        end else if (i_link.vld && w_in_use && w_s > r_best_s) begin
            r_best_s   <= w_s;
            r_best_row <= {1'b0, i_link.row} + LEN_W'(1);
        end
    end

    // merge with the best of the columns to the left
    always_comb begin
        w_own.score  = w_in_use ? r_best_s : SCORE_ZERO;
        w_own.row    = r_best_row;
        w_own.col    = {1'b0, i_idx} + LEN_W'(1);
        w_own_better = (w_own.score > i_best.score) ||
                       (w_own.score == i_best.score && w_own.score > SCORE_ZERO &&
                        w_own.row < i_best.row);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_best_out <= '0;
        end else begin
            r_best_out <= w_own_better ? w_own : i_best;
        end
    end

    assign o_link   = r_link;
    assign o_best   = r_best_out;
    assign o_tb_lab = r_tb_rd;

    `LAT_ASSERT_IMP(a_best_pos, r_best_s > SCORE_ZERO, r_best_row != '0)
    `LAT_ASSERT_NXT(a_row_order, i_link.vld && r_link.vld, o_link.row == $past(i_link.row))
    `LAT_ASSERT_NXT(a_link_idle, !i_link.vld, !o_link.vld)

endmodule

// ===== rtl/local_alignment_traceback.sv =====
// Local alignment engine built as a chain of column cells. Load, gap and
// read requests are taken one per cycle while busy is low; a read answers
// in the cycle after it is taken. A run first hands the scaled column gaps
// to the cells, then feeds the grid rows in one by one to start the wavefront,
// then waits for the wave to leave the chain and the best score to ripple
// out, then takes the traceback steps one by one; busy is high meanwhile.
// Each answer shows on the result ports for a single cycle under o_strobe
// and must be captured then: there is no way to hold it off.
`include "assert_macros.svh"

module local_alignment_traceback (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    output logic               o_busy,
    input  logic [2:0]         i_kind,
    input  logic [7:0]         i_row,
    input  logic [7:0]         i_col,
    input  logic signed [31:0] i_cell_score,
    input  logic signed [31:0] i_prof_score,
    input  logic signed [31:0] i_gap_value,
    output logic               o_strobe,
    output logic               o_answer_kind,
    output logic [30:0]        o_best_score,
    output logic [8:0]         o_best_row,
    output logic [8:0]         o_best_col,
    output logic               o_mapped_valid,
    output logic [7:0]         o_mapped_col,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [1:0]         i_cfg_index,
    input  logic [15:0]        i_cfg_data
);
    import lat_pkg::*;

    t_state           r_state, n_state;
    logic [LEN_W-1:0] r_cnt, n_cnt;
    logic [DRAIN_W-1:0] r_wait, n_wait;
    logic [LEN_W-1:0] r_ti, n_ti, r_tj, n_tj;
    logic [LEN_W-1:0] r_br, n_br, r_bc, n_bc;
    t_score           r_bs, n_bs;

    logic [FRAC_W-1:0] r_gap_ext;
    logic [LEN_W-1:0] r_rows, r_cols;
    logic [LEN_W-1:0] w_rows, w_cols;

    t_score           r_rg_mem [MAX_LEN];
    t_score           r_cg_mem [MAX_LEN];
    logic [IDX_W-1:0] r_map_col [MAX_LEN];
    logic             r_map_vld [MAX_LEN];
    logic [IDX_W-1:0] r_map_rd;

    logic             r_clear;
    logic             r_ld_vld;
    logic [IDX_W-1:0] r_ld_row, r_ld_col;
    t_score           r_ld_val;

    logic             r_p1_vld, r_p2_vld, r_p3_vld, r_p4_vld;
    logic             r_p1_sweep, r_p2_sweep, r_p3_sweep, r_p4_sweep;
    logic [IDX_W-1:0] r_p1_idx, r_p2_idx, r_p3_idx, r_p4_idx;
    t_score           r_p1_g, r_p2_g, r_p3_g, r_p4_g;
    logic [SCORE_W-1:0] r_p2_mag, r_p3_q;
    t_score           r_p4_scl;
    logic [SCORE_W+FRAC_W-1:0] w_prod;

    logic             r_strobe, r_akind, r_mval;
    logic [30:0]      r_out_score;
    logic [LEN_W-1:0] r_out_row, r_out_col;

    logic             w_accept, w_issue, w_sweep, w_map_we, w_run_done;
    logic [LEN_W-1:0] w_ti_m1, w_tj_m1;
    t_label           w_lab;
    t_ctl             w_ctl;
    t_link            w_link [MAX_LEN+1];
    t_best            w_best [MAX_LEN+1];
    t_label           w_tb_lab [MAX_LEN];

    assign w_accept    = i_start && !o_busy;
    assign o_busy      = (r_state != ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign w_rows = (r_rows > LEN_W'(MAX_LEN)) ? LEN_W'(MAX_LEN) : r_rows;
    assign w_cols = (r_cols > LEN_W'(MAX_LEN)) ? LEN_W'(MAX_LEN) : r_cols;
    assign w_ti_m1 = r_ti - LEN_W'(1);
    assign w_tj_m1 = r_tj - LEN_W'(1);

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gap_ext <= FRAC_W'(13107);
            r_rows    <= LEN_W'(MAX_LEN);
            r_cols    <= LEN_W'(MAX_LEN);
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_GAP_EXT: r_gap_ext <= i_cfg_data;
                CFG_ROWS:    r_rows    <= i_cfg_data[LEN_W-1:0];
                CFG_COLS:    r_cols    <= i_cfg_data[LEN_W-1:0];
                default: ;
            endcase
        end
    end

    // cell score load, summed on the way in
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ld_vld <= 1'b0;
        end else begin
            r_ld_vld <= w_accept && i_kind == KIND_CELL;
        end
        r_ld_row <= i_row;
        r_ld_col <= i_col;
        r_ld_val <= sat_add(i_cell_score, i_prof_score);
    end

    // run sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_clear <= 1'b0;
        end else begin
            r_state <= n_state;
            r_clear <= w_accept && i_kind == KIND_RUN;
        end
        r_cnt  <= n_cnt;
        r_wait <= n_wait;
        r_ti   <= n_ti;
        r_tj   <= n_tj;
        r_br   <= n_br;
        r_bc   <= n_bc;
        r_bs   <= n_bs;
    end

    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        n_wait     = r_wait;
        n_ti       = r_ti;
        n_tj       = r_tj;
        n_br       = r_br;
        n_bc       = r_bc;
        n_bs       = r_bs;
        w_issue    = 1'b0;
        w_map_we   = 1'b0;
        w_run_done = 1'b0;
        w_lab      = LAB_START;
        case (r_state)
            ST_IDLE: begin
                if (w_accept && i_kind == KIND_RUN) begin
                    n_state = ST_GAP_SWEEP;
                    n_cnt   = '0;
                end
            end
            ST_GAP_SWEEP: begin
                if (r_cnt == LEN_W'(MAX_LEN)) begin
                    n_state = ST_ROW_FEED;
                    n_cnt   = '0;
                end else begin
                    w_issue = 1'b1;
                    n_cnt   = r_cnt + LEN_W'(1);
                end
            end
            ST_ROW_FEED: begin
                if (r_cnt >= w_rows) begin
                    n_state = ST_DRAIN;
                    n_wait  = '0;
                end else begin
                    w_issue = 1'b1;
                    n_cnt   = r_cnt + LEN_W'(1);
                end
            end
            ST_DRAIN: begin
                if (r_wait == DRAIN_W'(DRAIN_CYC - 1)) begin
                    n_state = ST_TB_WAIT;
                    n_ti    = w_best[MAX_LEN].row;
                    n_tj    = w_best[MAX_LEN].col;
                    n_br    = w_best[MAX_LEN].row;
                    n_bc    = w_best[MAX_LEN].col;
                    n_bs    = w_best[MAX_LEN].score;
                end else begin
                    n_wait = r_wait + DRAIN_W'(1);
                end
            end
            ST_TB_WAIT: begin
                n_state = ST_TB_STEP;
            end
            ST_TB_STEP: begin
                if (r_ti != '0 && r_tj != '0) begin
                    w_lab = w_tb_lab[w_tj_m1[IDX_W-1:0]];
                end
                n_state = ST_TB_WAIT;
                case (w_lab)
                    LAB_START: begin
                        w_run_done = 1'b1;
                        n_state    = ST_IDLE;
                    end
                    LAB_ALIGN: begin
                        w_map_we = 1'b1;
                        n_ti     = w_ti_m1;
                        n_tj     = w_tj_m1;
                    end
                    LAB_DOWN:  n_ti = w_ti_m1;
                    LAB_RIGHT: n_tj = w_tj_m1;
                    default:   n_state = ST_IDLE;
                endcase
            end
            default: n_state = ST_IDLE;
        endcase
    end

    assign w_sweep = (r_state == ST_GAP_SWEEP);

    // gap stores and first stage of the gap scaling pipeline
    always_ff @(posedge i_clk) begin
        if (w_accept && i_kind == KIND_ROW_GAP) begin
            r_rg_mem[i_row] <= i_gap_value;
        end
        if (w_accept && i_kind == KIND_COL_GAP) begin
            r_cg_mem[i_col] <= i_gap_value;
        end
        r_p1_g <= w_sweep ? r_cg_mem[r_cnt[IDX_W-1:0]] : r_rg_mem[r_cnt[IDX_W-1:0]];
    end

    assign w_prod = (SCORE_W+FRAC_W)'(r_p2_mag) * (SCORE_W+FRAC_W)'(r_gap_ext);

    // magnitude, product, sign
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_vld <= 1'b0;
            r_p2_vld <= 1'b0;
            r_p3_vld <= 1'b0;
            r_p4_vld <= 1'b0;
        end else begin
            r_p1_vld <= w_issue;
            r_p2_vld <= r_p1_vld;
            r_p3_vld <= r_p2_vld;
            r_p4_vld <= r_p3_vld;
        end
        r_p1_sweep <= w_sweep;
        r_p1_idx   <= r_cnt[IDX_W-1:0];
        r_p2_sweep <= r_p1_sweep;
        r_p2_idx   <= r_p1_idx;
        r_p2_g     <= r_p1_g;
        r_p2_mag   <= r_p1_g[SCORE_W-1] ? SCORE_W'(-r_p1_g) : SCORE_W'(r_p1_g);
        r_p3_sweep <= r_p2_sweep;
        r_p3_idx   <= r_p2_idx;
        r_p3_g     <= r_p2_g;
        r_p3_q     <= w_prod[SCORE_W+FRAC_W-1:FRAC_W];
        r_p4_sweep <= r_p3_sweep;
        r_p4_idx   <= r_p3_idx;
        r_p4_g     <= r_p3_g;
        r_p4_scl   <= r_p3_g[SCORE_W-1] ? t_score'(-r_p3_q) : t_score'(r_p3_q);
    end

    // broadcast control to all cells
    always_comb begin
        w_ctl.clear  = r_clear;
        w_ctl.cg_we  = r_p4_vld && r_p4_sweep;
        w_ctl.cg_idx = r_p4_idx;
        w_ctl.cg     = r_p4_g;
        w_ctl.cg_scl = r_p4_scl;
        w_ctl.ld_we  = r_ld_vld;
        w_ctl.ld_row = r_ld_row;
        w_ctl.ld_col = r_ld_col;
        w_ctl.ld_val = r_ld_val;
        w_ctl.cols   = w_cols;
        w_ctl.tb_row = w_ti_m1[IDX_W-1:0];
    end

    // head of the chain
    assign w_link[0] = '{vld: r_p4_vld && !r_p4_sweep, row: r_p4_idx, s: SCORE_ZERO,
                         lab: LAB_START, gap: r_p4_g, gap_scl: r_p4_scl};
    assign w_best[0] = '0;

    // chain of column cells
    for (genvar g = 0; g < MAX_LEN; g++) begin : g_cell
        lat_cell u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_idx    (IDX_W'(g)),
            .i_ctl    (w_ctl),
            .i_link   (w_link[g]),
            .o_link   (w_link[g+1]),
            .i_best   (w_best[g]),
            .o_best   (w_best[g+1]),
            .o_tb_lab (w_tb_lab[g])
        );
    end

    // row mapping valid bits
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < MAX_LEN; k++) begin
            if (!i_rst_n || (w_accept && i_kind == KIND_RUN)) begin
                r_map_vld[k] <= 1'b0;
            end else if (w_map_we && w_ti_m1[IDX_W-1:0] == IDX_W'(k)) begin
                r_map_vld[k] <= 1'b1;
            end
        end
    end

    // row mapping columns
    always_ff @(posedge i_clk) begin
        if (w_map_we) begin
            r_map_col[w_ti_m1[IDX_W-1:0]] <= w_tj_m1[IDX_W-1:0];
        end
        r_map_rd <= r_map_col[i_row];
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= w_run_done || (w_accept && i_kind == KIND_READ);
        end
        r_akind     <= !w_run_done;
        r_out_score <= w_run_done ? r_bs[30:0] : '0;
        r_out_row   <= w_run_done ? r_br : '0;
        r_out_col   <= w_run_done ? r_bc : '0;
        r_mval      <= !w_run_done && r_map_vld[i_row];
    end

    assign o_strobe       = r_strobe;
    assign o_answer_kind  = r_akind;
    assign o_best_score   = r_out_score;
    assign o_best_row     = r_out_row;
    assign o_best_col     = r_out_col;
    assign o_mapped_valid = r_mval;
    assign o_mapped_col   = r_mval ? r_map_rd : '0;

    `LAT_ASSERT_IMP(a_run_best, o_strobe && !o_answer_kind, (o_best_score == '0) == (o_best_row == '0))
    `LAT_ASSERT_IMP(a_busy_end, $past(i_rst_n) && $fell(o_busy), o_strobe && !o_answer_kind)
    `LAT_ASSERT_IMP(a_tb_grid, r_state == ST_TB_STEP, r_ti <= w_rows && r_tj <= w_cols)
    `LAT_ASSERT_IMP(a_wave_rows, w_link[MAX_LEN].vld, {1'b0, w_link[MAX_LEN].row} < w_rows)
    `LAT_ASSERT_NXT(a_tb_pair, r_state == ST_TB_WAIT, r_state == ST_TB_STEP)

endmodule
